### sv/trimmed_line_receiver_defines.svh
// assertion helpers for the trimmed line receiver
`ifndef TRIMMED_LINE_RECEIVER_DEFINES_SVH
`define TRIMMED_LINE_RECEIVER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlr assertion failed");

// next-cycle implication
`define TLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlr assertion failed");

`endif

### sv/tlr_pkg.sv
package tlr_pkg;

  localparam int MAX_LINE   = 64;
  localparam int IDX_W      = $clog2(MAX_LINE);
  localparam int CAP_W      = 7;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_LINE);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_FAULT   = 2'd2;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // outcome of an accepted transaction
  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_EMPTY,
    DEC_LINE
  } dec_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic ptr_inc;
    logic load_char;
    logic load_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    dec_e dec;
    logic at_last;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/tlr_ctrl.sv
module tlr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tlr_pkg::dp_stat_t  stat_i,
  output tlr_pkg::ctrl_cmd_t cmd_o,
  output logic               in_stall_o
);
  import tlr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMPTY,
    S_RD,
    S_LD
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd_en      = (state_q == S_RD);
    cmd_o.load_empty = (state_q == S_EMPTY) && stat_i.out_free;
    cmd_o.load_char  = (state_q == S_LD) && stat_i.out_free;
    cmd_o.ptr_inc    = cmd_o.load_char && !stat_i.at_last;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (stat_i.dec)
              DEC_EMPTY: state_q <= S_EMPTY;
              DEC_LINE:  state_q <= S_RD;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_EMPTY: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        S_RD: begin
          state_q <= S_LD;
        end
        S_LD: begin
          if (stat_i.out_free) begin
            state_q <= stat_i.at_last ? S_IDLE : S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/tlr_datapath.sv
module tlr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             func_i,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             rx_fault_i,
  input  tlr_pkg::ctrl_cmd_t               cmd_i,
  output tlr_pkg::dp_stat_t                stat_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [7:0]                       out_char_o,
  output logic                             line_last_o,
  output logic                             line_empty_o,
  output logic [1:0]                       line_status_o
);
  import tlr_pkg::*;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // configuration
  logic [CAP_W-1:0] cap_q;
  logic [TMO_W-1:0] tmo_q;

  // line state
  logic [7:0]       mem [MAX_LINE];
  logic [IDX_W-1:0] fill_q, first_q, last_q;
  logic             text_q, nul_q, disc_q;
  logic [TMO_W-1:0] idle_q;

  // emission
  logic [IDX_W-1:0] rd_ptr_q, end_ptr_q;
  logic [7:0]       rd_data_q;
  logic [1:0]       empty_status_q;

  // output register
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q, out_empty_q;
  logic [1:0]       out_status_q;

  logic [CAP_W-1:0] cap_eff, limit;
  logic [TMO_W-1:0] idle_inc;
  logic [CAP_W-1:0] fill_ext, fill_inc;
  logic             is_eol, at_limit, tick_live, timed_out, store_byte;
  dec_e             dec;
  logic [1:0]       dec_status;

  always_comb begin
    if (cap_q < CAP_MIN)      cap_eff = CAP_MIN;
    else if (cap_q > CAP_MAX) cap_eff = CAP_MAX;
    else                      cap_eff = cap_q;
  end

  assign limit     = cap_eff - CAP_W'(1);
  assign fill_ext  = {{(CAP_W-IDX_W){1'b0}}, fill_q};
  assign fill_inc  = fill_ext + CAP_W'(1);
  assign at_limit  = (fill_ext >= limit);
  assign is_eol    = (rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF);
  assign idle_inc  = (idle_q != {TMO_W{1'b1}}) ? idle_q + TMO_W'(1) : idle_q;
  assign tick_live = !disc_q && (tmo_q != '0);
  assign timed_out = tick_live && (idle_inc >= tmo_q);
  assign store_byte = !rx_fault_i && !is_eol && !disc_q && !at_limit;

  always_comb begin
    dec        = DEC_NONE;
    dec_status = STATUS_OK;
    if (func_i == FUNC_TICK) begin
      if (timed_out) begin
        dec        = DEC_EMPTY;
        dec_status = STATUS_TIMEOUT;
      end
    end else if (rx_fault_i) begin
      dec        = DEC_EMPTY;
      dec_status = STATUS_FAULT;
    end else if (is_eol) begin
      dec = text_q ? DEC_LINE : DEC_EMPTY;
    end
  end

  assign stat_o.dec      = dec;
  assign stat_o.at_last  = (rd_ptr_q == end_ptr_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      tmo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_CAPACITY: cap_q <= cfg_data_i[CAP_W-1:0];
        REG_TIMEOUT_TICKS: tmo_q <= cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
      text_q  <= 1'b0;
      nul_q   <= 1'b0;
      disc_q  <= 1'b0;
      idle_q  <= '0;
    end else if (cmd_i.accept) begin
      if (dec != DEC_NONE) begin
        // line finished or dropped: start afresh
        fill_q  <= '0;
        first_q <= '0;
        last_q  <= '0;
        text_q  <= 1'b0;
        nul_q   <= 1'b0;
        disc_q  <= 1'b0;
        idle_q  <= '0;
      end else if (func_i == FUNC_TICK) begin
        if (tick_live) idle_q <= idle_inc;
      end else begin
        idle_q <= '0;
        if (!store_byte) begin
          disc_q <= 1'b1;
        end else begin
          fill_q <= fill_inc[IDX_W-1:0];
          disc_q <= (fill_inc >= limit);
          if (!nul_q) begin
            if (rx_byte_i == CHAR_NUL) begin
              nul_q <= 1'b1;
            end else if (!is_blank(rx_byte_i)) begin
              if (!text_q) begin
                first_q <= fill_q;
                text_q  <= 1'b1;
              end
              last_q <= fill_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (func_i == FUNC_BYTE) && store_byte) begin
      mem[fill_q] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q       <= '0;
      end_ptr_q      <= '0;
      empty_status_q <= STATUS_OK;
    end else if (cmd_i.accept) begin
      rd_ptr_q       <= first_q;
      end_ptr_q      <= last_q;
      empty_status_q <= dec_status;
    end else if (cmd_i.ptr_inc) begin
      rd_ptr_q <= rd_ptr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_char || cmd_i.load_empty) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      out_char_q   <= rd_data_q;
      out_last_q   <= stat_o.at_last;
      out_empty_q  <= 1'b0;
      out_status_q <= STATUS_OK;
    end else if (cmd_i.load_empty) begin
      out_char_q   <= CHAR_NUL;
      out_last_q   <= 1'b1;
      out_empty_q  <= 1'b1;
      out_status_q <= empty_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign line_last_o   = out_last_q;
  assign line_empty_o  = out_empty_q;
  assign line_status_o = out_status_q;

endmodule

### sv/trimmed_line_receiver.sv
// channel   direction  handshake               payload
// input     in         in_valid_i/in_stall_o   func_i rx_byte_i rx_fault_i
// result    out        out_valid_o/out_stall_i out_char_o line_last_o
//                                              line_empty_o line_status_o
// config    in         cfg_we_i                cfg_idx_i cfg_data_i
//
// a byte or tick transaction that yields no result leaves the input free
// a line end emits n trimmed bytes, each by a memory read, then an output
// register load, which waits on output stalls; an empty line result is one load
// input is stalled from the transaction that yields results until the last
// result is loaded; reset clears all control state, the line store is not cleared
`include "trimmed_line_receiver_defines.svh"

module trimmed_line_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           rx_fault_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_char_o,
  output logic                           line_last_o,
  output logic                           line_empty_o,
  output logic [1:0]                     line_status_o
);
  import tlr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  tlr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .rx_byte_i     (rx_byte_i),
    .rx_fault_i    (rx_fault_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .line_last_o   (line_last_o),
    .line_empty_o  (line_empty_o),
    .line_status_o (line_status_o)
  );

  // a result load never lands on a transaction being taken
  `TLR_ASSERT_IMP(a_accept_no_load, cmd.accept, !(cmd.load_char || cmd.load_empty))
  // a pending result is never overwritten
  `TLR_ASSERT_IMP(a_load_free, cmd.load_char || cmd.load_empty, stat.out_free)
  // a transaction that yields results holds off the next one
  `TLR_ASSERT_NXT(a_busy_after_dec, cmd.accept && (stat.dec != DEC_NONE), in_stall_o)

endmodule
